// ----- src/heightmap_bilinear_sampler_macros.svh -----
// Assertion macros for the heightmap sampler.
// HBS_ASSERT checks a property on every clock edge out of reset.
// HBS_ASSERT_NEXT checks that an antecedent is followed by a consequent in the next cycle.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_MACROS_SVH

`ifndef SYNTH
`define HBS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define HBS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HBS_ASSERT(name, clk, rst_n, prop)
`define HBS_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/hbs_pkg.sv -----
`timescale 1ns / 1ps
package hbs_pkg;

  localparam int POS_BITS    = 22;
  localparam int ADDR_W      = 16;
  localparam int HEIGHT_W    = 8;
  localparam int OUT_W       = 16;
  localparam int CFG_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int MAX_TILES   = 255;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_TILES  = 2'd2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // floor(u / 5) for u < 2^24: (u * ceil(2^27 / 5)) >> 27
  localparam int          DIV_IN_W  = 24;
  localparam int          DIV_Q_W   = 22;
  localparam int          DIV5_K    = 27;
  localparam logic [24:0] DIV5_M    = 25'd26843546;
  // bias 5 * 2^21 keeps the dividend positive; it comes out as 2^21
  localparam logic [DIV_IN_W-1:0] DIV5_BIAS = 24'd10485760;
  localparam logic [DIV_Q_W-1:0]  DIV5_QOFF = 22'h200000;

  // floor(x / 5) for x <= 1024: (x * ceil(2^13 / 5)) >> 13
  localparam int           DIV5S_K = 13;
  localparam logic [10:0]  DIV5S_M = 11'd1639;

  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [HEIGHT_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] a00;
    logic [ADDR_W-1:0] a01;
    logic [ADDR_W-1:0] a10;
    logic [ADDR_W-1:0] a11;
  } mem_rd_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] h00;
    logic [HEIGHT_W-1:0] h01;
    logic [HEIGHT_W-1:0] h10;
    logic [HEIGHT_W-1:0] h11;
  } corner_t;

  // Zero acts as one, values above the tile limit saturate.
  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] r);
    logic [CFG_W-1:0] s;
    s = r;
    if (r == '0) begin
      s = CFG_W'(1);
    end else if (int'(r) > MAX_TILES) begin
      s = CFG_W'(MAX_TILES);
    end
    return s;
  endfunction

endpackage

// ----- src/hbs_coord.sv -----
`timescale 1ns / 1ps
module hbs_coord import hbs_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter bit FLIP      = 1'b0
) (
  input  logic                       clk_i,
  input  logic signed [POS_BITS-1:0] pos_i,
  input  logic [CFG_W-1:0]           edge_i,
  input  logic [CFG_W-1:0]           limit_i,
  output logic [CFG_W-1:0]           idx_o,
  output logic [FRAC_BITS-1:0]       frac_o
);

  localparam int SH  = (FRAC_BITS > 8) ? FRAC_BITS - 8 : 0;
  localparam int DN  = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;
  localparam int CLW = CFG_W + FRAC_BITS;
  localparam int CW  = ((POS_BITS + SH > CLW) ? POS_BITS + SH : CLW) + 3;
  localparam int PW  = DIV_IN_W + 25;

  // stage 1: scale and bias
  logic signed [POS_BITS-1:0] v;
  logic signed [DIV_IN_W-1:0] v_ext;
  logic [DIV_IN_W-1:0]        u_d, u_q;
  // stage 2: reciprocal multiply
  logic [PW-1:0]              prod;
  logic [DIV_Q_W-1:0]         qu_d, qu_q;
  logic [DIV_IN_W-1:0]        u2_q;
  // stage 3: grid coordinate
  logic signed [DIV_Q_W-1:0]  q;
  logic [DIV_IN_W-1:0]        rem_full;
  logic [2:0]                 r;
  logic [10:0]                rs;
  logic [21:0]                small_prod;
  logic [8:0]                 rem_frac;
  logic signed [CW-1:0]       q_ext, world, edge_s, lim_s, g_d, g_q;
  // stage 4: clamp
  logic [CLW-1:0]             top, c;
  logic signed [CW-1:0]       top_s;
  logic [CFG_W-1:0]           idx_d;
  logic [FRAC_BITS-1:0]       frac_d;

  always_comb begin
    v     = pos_i >>> DN;
    v_ext = DIV_IN_W'(v);
    u_d   = DIV_IN_W'($unsigned(v_ext) + DIV5_BIAS);
  end

  always_comb begin
    prod = PW'(u_q) * PW'(DIV5_M);
    qu_d = prod[DIV5_K +: DIV_Q_W];
  end

  always_comb begin
    q          = $signed(qu_q - DIV5_QOFF);
    rem_full   = u2_q - (DIV_IN_W'(qu_q) + {qu_q, 2'b00});
    r          = rem_full[2:0];
    // remainder carries SH more fraction bits into the quotient
    rs         = 11'(r) << SH;
    small_prod = 22'(rs) * 22'(DIV5S_M);
    rem_frac   = small_prod[DIV5S_K +: 9];
    q_ext      = CW'(q);
    world      = (q_ext <<< SH) + $signed(CW'(rem_frac));
    edge_s     = $signed(CW'({edge_i, {FRAC_BITS{1'b0}}}));
    lim_s      = $signed(CW'({limit_i, {FRAC_BITS{1'b0}}}));
    if (FLIP) begin
      g_d = lim_s - edge_s - world;
    end else begin
      g_d = edge_s + world;
    end
  end

  always_comb begin
    top   = {limit_i, {FRAC_BITS{1'b0}}} - CLW'(1);
    top_s = $signed(CW'(top));
    if (g_q[CW-1]) begin
      c = '0;
    end else if (g_q > top_s) begin
      c = top;
    end else begin
      c = g_q[CLW-1:0];
    end
    idx_d  = c[CLW-1:FRAC_BITS];
    frac_d = c[FRAC_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    u_q    <= u_d;
    qu_q   <= qu_d;
    u2_q   <= u_q;
    g_q    <= g_d;
    idx_o  <= idx_d;
    frac_o <= frac_d;
  end

endmodule

// ----- src/hbs_vertex_mem.sv -----
`timescale 1ns / 1ps
module hbs_vertex_mem import hbs_pkg::*; (
  input  logic    clk_i,
  input  mem_wr_t wr_i,
  input  mem_rd_t rd_i,
  output corner_t data_o
);

  localparam int DEPTH = 2 ** ADDR_W;

  // two copies, each with two read ports: one for each row of the cell
  logic [HEIGHT_W-1:0] mem_a [DEPTH];
  logic [HEIGHT_W-1:0] mem_b [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_a[wr_i.addr] <= wr_i.data;
      mem_b[wr_i.addr] <= wr_i.data;
    end
    data_o.h00 <= mem_a[rd_i.a00];
    data_o.h01 <= mem_a[rd_i.a01];
    data_o.h10 <= mem_b[rd_i.a10];
    data_o.h11 <= mem_b[rd_i.a11];
  end

endmodule

// ----- src/hbs_blend.sv -----
`timescale 1ns / 1ps
module hbs_blend import hbs_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk_i,
  input  corner_t              corners_i,
  input  logic [FRAC_BITS-1:0] fx_i,
  input  logic [FRAC_BITS-1:0] fy_i,
  output logic [OUT_W-1:0]     result_o
);

  localparam int TW  = HEIGHT_W + FRAC_BITS;
  localparam int AW  = HEIGHT_W + 2 * FRAC_BITS;
  localparam int RSH = 2 * FRAC_BITS - 8;

  logic [FRAC_BITS:0]   wx, wy;
  logic [TW-1:0]        top_d, top_q, bot_d, bot_q;
  logic [FRAC_BITS-1:0] fy_q;
  logic [AW-1:0]        acc_d, acc_q;
  logic [OUT_W-1:0]     res_d;

  always_comb begin
    wx    = (FRAC_BITS + 1)'(1 << FRAC_BITS) - (FRAC_BITS + 1)'(fx_i);
    top_d = TW'((TW + 1)'(corners_i.h00) * (TW + 1)'(wx)
              + (TW + 1)'(corners_i.h01) * (TW + 1)'(fx_i));
    bot_d = TW'((TW + 1)'(corners_i.h10) * (TW + 1)'(wx)
              + (TW + 1)'(corners_i.h11) * (TW + 1)'(fx_i));
  end

  always_comb begin
    wy    = (FRAC_BITS + 1)'(1 << FRAC_BITS) - (FRAC_BITS + 1)'(fy_q);
    acc_d = AW'((AW + 1)'(top_q) * (AW + 1)'(wy) + (AW + 1)'(bot_q) * (AW + 1)'(fy_q));
  end

  generate
    if (RSH > 0) begin : g_round
      logic [AW:0] rnd;
      // round half up to 8 fraction bits
      always_comb begin
        rnd   = {1'b0, acc_q} + ((AW + 1)'(1) << (RSH - 1));
        res_d = rnd[RSH +: OUT_W];
      end
    end else begin : g_exact
      always_comb begin
        res_d = acc_q[OUT_W-1:0];
      end
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    bot_q    <= bot_d;
    fy_q     <= fy_i;
    acc_q    <= acc_d;
    result_o <= res_d;
  end

endmodule

// ----- src/heightmap_bilinear_sampler.sv -----
`timescale 1ns / 1ps
// Bilinear heightmap sampler.
// Command channel: an item is taken at each rising edge with start_i high and
// busy_o low. kind_i selects a vertex load (vertex_index_i, vertex_height_i)
// or a height query (pos_x_i, pos_y_i, signed, 8 fraction bits).
// Result channel: each query returns sampled_height_o, shown for one cycle
// with done_o high. Loads return nothing. The receiver cannot stall, so the
// pipeline never holds and busy_o is low at all times out of reset.
// Throughput: one item per cycle, loads and queries freely mixed.
// A query's result passes the coordinate stages, the cell address register, the
// store read and the blend registers before it reaches the ports. The vertex
// store is two copies of a 64K x 8 synchronous memory with two read ports
// each, read in the sixth pipeline stage; loads write in that same stage so
// every query sees exactly the loads taken before it.
// Configuration: cfg_we_i writes cfg_wdata_i to the register at cfg_idx_i
// (0 grid_width, 1 grid_height, 2 edge_tiles) at once; write only while idle.
// Reset: busy_o is high during reset, registers return to 64, 64, 0, and the
// pipeline is emptied. The store is not cleared; load every vertex that a
// query can touch before querying.
`include "heightmap_bilinear_sampler_macros.svh"
module heightmap_bilinear_sampler import hbs_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       kind_i,
  input  logic [ADDR_W-1:0]          vertex_index_i,
  input  logic [HEIGHT_W-1:0]        vertex_height_i,
  input  logic signed [POS_BITS-1:0] pos_x_i,
  input  logic signed [POS_BITS-1:0] pos_y_i,
  output logic                       done_o,
  output logic [OUT_W-1:0]           sampled_height_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i
);

  localparam int QLAT = 9;
  localparam int LDST = 5;

  logic                 busy_q;
  logic                 accept;
  logic [CFG_W-1:0]     grid_w_q, grid_h_q, edge_q;
  logic [CFG_W-1:0]     grid_w_d, grid_h_d, edge_d;
  logic [CFG_W-1:0]     eff_w, eff_h;
  logic [CFG_W:0]       stride;
  logic [QLAT-1:0]      qv_q, qv_d;
  logic [LDST-1:0]      ld_v_q, ld_v_d;
  logic [ADDR_W-1:0]    ld_addr_q [LDST];
  logic [HEIGHT_W-1:0]  ld_data_q [LDST];
  logic [CFG_W-1:0]     ix, iy;
  logic [FRAC_BITS-1:0] fx4, fy4, fx5_q, fy5_q, fx6_q, fy6_q;
  logic [ADDR_W-1:0]    a00_d, a00_q;
  logic [ADDR_W:0]      cell_lin;
  mem_wr_t              wr;
  mem_rd_t              rd;
  corner_t              corners;

  assign accept = start_i && !busy_q;
  assign busy_o = busy_q;
  assign eff_w  = eff_size(grid_w_q);
  assign eff_h  = eff_size(grid_h_q);
  assign stride = (CFG_W + 1)'(eff_w) + (CFG_W + 1)'(1);

  always_comb begin
    grid_w_d = grid_w_q;
    grid_h_d = grid_h_q;
    edge_d   = edge_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_WIDTH:  grid_w_d = cfg_wdata_i;
        REG_GRID_HEIGHT: grid_h_d = cfg_wdata_i;
        REG_EDGE_TILES:  edge_d   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    qv_d   = {qv_q[QLAT-2:0], accept && (kind_i == KIND_QUERY)};
    ld_v_d = {ld_v_q[LDST-2:0], accept && (kind_i == KIND_LOAD)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b1;
      grid_w_q <= CFG_W'(64);
      grid_h_q <= CFG_W'(64);
      edge_q   <= '0;
      qv_q     <= '0;
      ld_v_q   <= '0;
    end else begin
      busy_q   <= 1'b0;
      grid_w_q <= grid_w_d;
      grid_h_q <= grid_h_d;
      edge_q   <= edge_d;
      qv_q     <= qv_d;
      ld_v_q   <= ld_v_d;
    end
  end

  // delay loads so they write in the same stage where queries read
  always_ff @(posedge clk_i) begin
    ld_addr_q[0] <= vertex_index_i;
    ld_data_q[0] <= vertex_height_i;
    for (int i = 1; i < LDST; i++) begin
      ld_addr_q[i] <= ld_addr_q[i-1];
      ld_data_q[i] <= ld_data_q[i-1];
    end
  end

  hbs_coord #(.FRAC_BITS(FRAC_BITS), .FLIP(1'b0)) u_coord_x (
    .clk_i   (clk_i),
    .pos_i   (pos_x_i),
    .edge_i  (edge_q),
    .limit_i (eff_w),
    .idx_o   (ix),
    .frac_o  (fx4)
  );

  hbs_coord #(.FRAC_BITS(FRAC_BITS), .FLIP(1'b1)) u_coord_y (
    .clk_i   (clk_i),
    .pos_i   (pos_y_i),
    .edge_i  (edge_q),
    .limit_i (eff_h),
    .idx_o   (iy),
    .frac_o  (fy4)
  );

  always_comb begin
    cell_lin = (ADDR_W + 1)'(iy) * (ADDR_W + 1)'(stride) + (ADDR_W + 1)'(ix);
    a00_d    = cell_lin[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    a00_q <= a00_d;
    fx5_q <= fx4;
    fy5_q <= fy4;
    fx6_q <= fx5_q;
    fy6_q <= fy5_q;
  end

  always_comb begin
    wr.en   = ld_v_q[LDST-1];
    wr.addr = ld_addr_q[LDST-1];
    wr.data = ld_data_q[LDST-1];
    rd.a00  = a00_q;
    rd.a01  = a00_q + ADDR_W'(1);
    rd.a10  = a00_q + ADDR_W'(stride);
    rd.a11  = a00_q + ADDR_W'(stride) + ADDR_W'(1);
  end

  hbs_vertex_mem u_mem (
    .clk_i  (clk_i),
    .wr_i   (wr),
    .rd_i   (rd),
    .data_o (corners)
  );

  hbs_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk_i     (clk_i),
    .corners_i (corners),
    .fx_i      (fx6_q),
    .fy_i      (fy6_q),
    .result_o  (sampled_height_o)
  );

  assign done_o = qv_q[QLAT-1];

  `HBS_ASSERT(a_stage_single_item, clk_i, rst_ni, !(ld_v_q[LDST-1] && qv_q[LDST-1]))
  `HBS_ASSERT(a_done_from_query, clk_i, rst_ni, !done_o || $past(accept && kind_i, QLAT))
  `HBS_ASSERT(a_write_from_load, clk_i, rst_ni, !wr.en || $past(accept && !kind_i, LDST))
  `HBS_ASSERT_NEXT(a_range, clk_i, rst_ni, qv_q[QLAT-2], sampled_height_o <= OUT_W'(65280))

endmodule

// ----- bench/heightmap_bilinear_sampler_test.sv -----
`timescale 1ns / 1ps
module heightmap_bilinear_sampler_test;
  import hbs_pkg::*;

  localparam int GRID_FRAC       = 8;
  localparam int GRID_ONE        = 1 << GRID_FRAC;
  localparam int OUT_FRAC        = 8;
  localparam int STORE_DEPTH     = 1 << ADDR_W;
  localparam int SETTLE_CYCLES   = 12;
  localparam int WATCHDOG_CYCLES = 400;

  localparam logic [CFG_IDX_W-1:0]       REG_UNUSED = 2'd3;
  localparam logic signed [POS_BITS-1:0] POS_MAX    = 22'sh1FFFFF;
  localparam logic signed [POS_BITS-1:0] POS_MIN    = 22'sh200000;

  class height_scoreboard;
    logic [HEIGHT_W-1:0] vertex_mem [0:STORE_DEPTH-1];
    bit                  vertex_set [0:STORE_DEPTH-1];
    logic [CFG_W-1:0]    width_reg;
    logic [CFG_W-1:0]    height_reg;
    logic [CFG_W-1:0]    border_reg;
    logic [OUT_W-1:0]    heights_due [$];
    int                  errors;
    int                  loads;
    int                  queries;
    int                  checked;

    function new();
      width_reg  = 8'd64;
      height_reg = 8'd64;
      border_reg = 8'd0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_GRID_WIDTH: width_reg = val;
        REG_GRID_HEIGHT: height_reg = val;
        REG_EDGE_TILES: border_reg = val;
        default: ;
      endcase
    endfunction

    // zero grid size acts as one tile, oversized values saturate
    function int tiles(logic [CFG_W-1:0] r);
      if (r == '0) return 1;
      if (int'(r) > MAX_TILES) return MAX_TILES;
      return int'(r);
    endfunction

    // floor(p * ONE / 1280), rounding toward minus infinity
    function longint grid_coord(logic signed [POS_BITS-1:0] p);
      longint num;
      longint q;
      num = longint'(p) * GRID_ONE;
      q = num / 1280;
      if (num % 1280 != 0 && num < 0) q -= 1;
      return q;
    endfunction

    function longint clamp(longint c, int lim);
      longint hi;
      hi = longint'(lim) * GRID_ONE - 1;
      if (c < 0) c = 0;
      if (c > hi) c = hi;
      return c;
    endfunction

    function void locate(input logic signed [POS_BITS-1:0] px, py,
                         output logic [3:0][ADDR_W-1:0] corner,
                         output longint fx, fy);
      longint wt, ht, stride, gx, gy, ix, iy;
      wt = tiles(width_reg);
      ht = tiles(height_reg);
      stride = wt + 1;
      gx = clamp(longint'(border_reg) * GRID_ONE + grid_coord(px), int'(wt));
      gy = clamp(ht * GRID_ONE - longint'(border_reg) * GRID_ONE - grid_coord(py), int'(ht));
      ix = gx >> GRID_FRAC;
      iy = gy >> GRID_FRAC;
      fx = gx % GRID_ONE;
      fy = gy % GRID_ONE;
      corner[0] = ADDR_W'(iy * stride + ix);
      corner[1] = ADDR_W'(iy * stride + ix + 1);
      corner[2] = ADDR_W'((iy + 1) * stride + ix);
      corner[3] = ADDR_W'((iy + 1) * stride + ix + 1);
    endfunction

    function void note_item(logic kind, logic [ADDR_W-1:0] idx, logic [HEIGHT_W-1:0] hgt,
                            logic signed [POS_BITS-1:0] px, logic signed [POS_BITS-1:0] py);
      logic [3:0][ADDR_W-1:0] corner;
      longint fx, fy, top, bot, acc;
      if (kind == KIND_LOAD) begin
        vertex_mem[idx] = hgt;
        vertex_set[idx] = 1'b1;
        loads++;
        return;
      end
      locate(px, py, corner, fx, fy);
      top = longint'(vertex_mem[corner[0]]) * (GRID_ONE - fx)
          + longint'(vertex_mem[corner[1]]) * fx;
      bot = longint'(vertex_mem[corner[2]]) * (GRID_ONE - fx)
          + longint'(vertex_mem[corner[3]]) * fx;
      acc = top * (GRID_ONE - fy) + bot * fy;
      // round half up down to the output fraction
      acc = (acc + (longint'(1) << (2 * GRID_FRAC - OUT_FRAC - 1))) >> (2 * GRID_FRAC - OUT_FRAC);
      heights_due = {heights_due, OUT_W'(acc)};
      queries++;
    endfunction

    function void check_height(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (heights_due.size() == 0) begin
        $error("sampled_height: result with no query pending, expected none, actual %0d", got);
        errors++;
        return;
      end
      want = heights_due.pop_front();
      checked++;
      if (got !== want) begin
        $error("sampled_height mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start_i = 1'b0;
  logic                       busy_o;
  logic                       kind_i = KIND_LOAD;
  logic [ADDR_W-1:0]          vertex_index_i = '0;
  logic [HEIGHT_W-1:0]        vertex_height_i = '0;
  logic signed [POS_BITS-1:0] pos_x_i = '0;
  logic signed [POS_BITS-1:0] pos_y_i = '0;
  logic                       done_o;
  logic [OUT_W-1:0]           sampled_height_o;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i = REG_GRID_WIDTH;
  logic [CFG_W-1:0]           cfg_wdata_i = '0;

  height_scoreboard board = new();
  int  items_sent = 0;
  int  settings_run = 0;
  int  quiet = 0;
  bit  gaps_on = 1'b1;

  heightmap_bilinear_sampler #(.FRAC_BITS(GRID_FRAC)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .vertex_index_i  (vertex_index_i),
    .vertex_height_i (vertex_height_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .done_o          (done_o),
    .sampled_height_o(sampled_height_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) board.write_reg(cfg_idx_i, cfg_wdata_i);
      if (done_o) board.check_height(sampled_height_o);
      if (start_i && !busy_o) begin
        board.note_item(kind_i, vertex_index_i, vertex_height_i, pos_x_i, pos_y_i);
      end
      if ((start_i && !busy_o) || done_o || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_CYCLES) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_item(input logic kind, input logic [ADDR_W-1:0] idx,
                           input logic [HEIGHT_W-1:0] hgt,
                           input logic signed [POS_BITS-1:0] px,
                           input logic signed [POS_BITS-1:0] py);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    kind_i          <= kind;
    vertex_index_i  <= idx;
    vertex_height_i <= hgt;
    pos_x_i         <= px;
    pos_y_i         <= py;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  // Load whatever corners the query touches that were never written (all of them
  // with the given height when fill is not negative), then send the query.
  task automatic query_at(input logic signed [POS_BITS-1:0] px,
                          input logic signed [POS_BITS-1:0] py, input int fill);
    logic [3:0][ADDR_W-1:0] corner;
    longint fx, fy;
    bit [3:0] need;
    board.locate(px, py, corner, fx, fy);
    for (int k = 0; k < 4; k++) need[k] = fill >= 0 || !board.vertex_set[corner[k]];
    for (int k = 0; k < 4; k++) begin
      if (need[k]) begin
        send_item(KIND_LOAD, corner[k], fill >= 0 ? HEIGHT_W'(fill) : HEIGHT_W'($urandom),
                  POS_BITS'($urandom), POS_BITS'($urandom));
      end
    end
    send_item(KIND_QUERY, ADDR_W'($urandom), HEIGHT_W'($urandom), px, py);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (board.heights_due.size() != 0) @(posedge clk_i);
    // loads may still be in the pipe
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [CFG_W-1:0] b);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_GRID_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= REG_UNUSED;
    cfg_wdata_i <= CFG_W'($urandom);
    @(posedge clk_i);
    cfg_idx_i   <= REG_GRID_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_idx_i   <= REG_EDGE_TILES;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    // let the last write reach the predictor before picking positions
    @(posedge clk_i);
    settings_run++;
  endtask

  function automatic logic signed [POS_BITS-1:0] pick_x();
    int span, u, r;
    span = board.tiles(board.width_reg) * GRID_ONE;
    r = $urandom_range(0, 9);
    if (r == 0) return POS_BITS'($urandom);
    if (r == 1) u = int'($urandom_range(0, span + 1200)) - 600;
    else u = int'($urandom_range(0, span - 1));
    return POS_BITS'((u - int'(board.border_reg) * GRID_ONE) * 5 + int'($urandom_range(0, 4)));
  endfunction

  function automatic logic signed [POS_BITS-1:0] pick_y();
    int span, v, r;
    span = board.tiles(board.height_reg) * GRID_ONE;
    r = $urandom_range(0, 9);
    if (r == 0) return POS_BITS'($urandom);
    if (r == 1) v = int'($urandom_range(0, span + 1200)) - 600;
    else v = int'($urandom_range(0, span - 1));
    return POS_BITS'((span - int'(board.border_reg) * GRID_ONE - v) * 5
                     + int'($urandom_range(0, 4)));
  endfunction

  task automatic random_phase(input int count, input bit allow_gaps);
    int stop, r, lim, step;
    stop = items_sent + count;
    step = 0;
    while (items_sent < stop) begin
      if (step % 12 == 0) gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
      step++;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        query_at(pick_x(), pick_y(), -1);
      end else if (r < 90) begin
        lim = (board.tiles(board.height_reg) + 1) * (board.tiles(board.width_reg) + 1) - 1;
        send_item(KIND_LOAD, ADDR_W'($urandom_range(0, lim)), HEIGHT_W'($urandom),
                  POS_BITS'($urandom), POS_BITS'($urandom));
      end else begin
        send_item(KIND_LOAD, ADDR_W'($urandom), HEIGHT_W'($urandom),
                  POS_BITS'($urandom), POS_BITS'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default grid: 64 x 64 tiles, no border
    send_item(KIND_LOAD, 16'hFFFF, 8'hFF, POS_MAX, POS_MIN);
    send_item(KIND_LOAD, 16'h0000, 8'h00, POS_MIN, POS_MAX);
    query_at(22'sd0, 22'sd0, 255);
    query_at(POS_MAX, POS_MAX, 0);
    query_at(POS_MIN, POS_MIN, -1);
    query_at(22'sd12800, 22'sd56320, -1);
    query_at(22'sd13440, 22'sd55680, -1);
    query_at(-22'sd1, -22'sd1, -1);
    random_phase(200, 1'b1);

    program_grid(8'd1, 8'd1, 8'd0);
    random_phase(150, 1'b1);
    program_grid(8'd255, 8'd255, 8'd255);
    random_phase(250, 1'b1);
    program_grid(8'd0, 8'd0, 8'd3);
    random_phase(120, 1'b1);
    program_grid(8'd255, 8'd1, 8'd0);
    random_phase(120, 1'b1);
    program_grid(8'd1, 8'd255, 8'd200);
    random_phase(120, 1'b1);
    repeat (3) begin
      program_grid(CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 40)),
                   CFG_W'($urandom_range(0, 255)));
      random_phase(150, 1'b1);
    end
    program_grid(CFG_W'($urandom_range(1, 30)), CFG_W'($urandom_range(1, 30)),
                 CFG_W'($urandom_range(0, 10)));
    random_phase(200, 1'b0);

    settle();
    $display("Sent %0d vertex loads and %0d height queries over %0d grid settings",
             board.loads, board.queries, settings_run + 1);
    $display("Compared %0d sampled heights, %0d failures", board.checked, board.errors);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/hbs_pkg.sv
src/hbs_coord.sv
src/hbs_vertex_mem.sv
src/hbs_blend.sv
src/heightmap_bilinear_sampler.sv
bench/heightmap_bilinear_sampler_test.sv
